/* rtl/ssi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_pkg
// Widths, constants and pipeline payload types of the swept sphere test.
// ----------------------------------------------------------------------------
package ssi_pkg;

  // Fixed point format of the coordinates
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned TIME_BITS = 16;

  // Data widths
  localparam int unsigned CW = 32;             // coordinate
  localparam int unsigned DW = CW + 1;         // coordinate difference
  localparam int unsigned PW = 2 * DW;         // product of two differences
  localparam int unsigned SW = PW + 2;         // sum of three products, signed
  localparam int unsigned QW = TIME_BITS + 1;  // contact time, Q1.16
  localparam int unsigned NW = 2 * PW;         // discriminant terms
  localparam int unsigned HW = 88;             // search slope term, signed
  localparam int unsigned FW = 104;            // search value term, signed
  localparam int unsigned MW = DW + QW + 1;    // position offset product

  localparam logic [QW-1:0] TIME_ONE = QW'(1) << TIME_BITS;

  // Squared length at or below which the sweep counts as no movement
  localparam logic [PW-1:0] MIN_MOVE_SQ =
    PW'((64'd1 << (2 * FRAC_BITS)) / 64'd100000000);

  // Geometry carried along the whole pipeline
  typedef struct packed {
    logic [2:0][CW-1:0] s;  // start centre
    logic [2:0][DW-1:0] m;  // movement, end minus start
  } geom_t;

  // Early outcome flags of one query
  typedef struct packed {
    logic ovl;   // spheres overlap at the start
    logic tiny;  // movement too short
    logic away;  // moving away from the target
    logic vb;    // vertex of the quadratic lies beyond the end
    logic p1le;  // quadratic at the end point is not positive
  } flags_t;

  // One slot of the contact time search
  typedef struct packed {
    geom_t                 g;
    logic [QW-1:0]         q;
    logic signed [FW-1:0]  f;
    logic signed [HW-1:0]  h;
    logic [PW-1:0]         a;
    logic                  hit;
    logic                  ovl;
  } srch_t;

endpackage

/* rtl/swept_sphere_intersection.sv */
`timescale 1ns / 1ps
// Pipeline: 7 setup stages, 17 time search stages, 2 position stages, in that order.
// Throughput: one query per cycle while the output is not stalled.
// An output stall freezes the whole pipeline until the held result is taken.
// Reset clears the stage valid bits only; the payload registers are not reset.
// ----------------------------------------------------------------------------
// swept_sphere_intersection
// Swept sphere against sphere contact test: solves for the first contact
// time along the sweep and returns the time and the contact centre.
// ----------------------------------------------------------------------------
module swept_sphere_intersection
  import ssi_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [31:0]   start_x_i,
  input  logic signed [31:0]   start_y_i,
  input  logic signed [31:0]   start_z_i,
  input  logic signed [31:0]   end_x_i,
  input  logic signed [31:0]   end_y_i,
  input  logic signed [31:0]   end_z_i,
  input  logic [30:0]          mover_radius_i,
  input  logic signed [31:0]   target_x_i,
  input  logic signed [31:0]   target_y_i,
  input  logic signed [31:0]   target_z_i,
  input  logic [30:0]          target_radius_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 hit_o,
  output logic [16:0]          hit_time_o,
  output logic signed [31:0]   hit_x_o,
  output logic signed [31:0]   hit_y_o,
  output logic signed [31:0]   hit_z_o
);

  localparam int unsigned SRCH0 = 6;
  localparam int unsigned NS    = SRCH0 + QW + 3;

  // Pipeline control: advance unless a finished result is held
  logic          en;
  logic [NS-1:0] v_q;

  assign en          = !(v_q[NS-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = v_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  // Stage 0: differences and radius sum
  logic [2:0][CW-1:0] s_in, e_in, t_in;
  geom_t              g0_d, g0_q;
  logic [2:0][DW-1:0] o_d, o_q, n_d, n_q;
  logic [CW-1:0]      rsum_d, rsum_q;

  assign s_in = {start_z_i, start_y_i, start_x_i};
  assign e_in = {end_z_i, end_y_i, end_x_i};
  assign t_in = {target_z_i, target_y_i, target_x_i};

  always_comb begin
    g0_d.s = s_in;
    for (int i = 0; i < 3; i++) begin
      g0_d.m[i] = DW'($signed(e_in[i])) - DW'($signed(s_in[i]));
      o_d[i]    = DW'($signed(s_in[i])) - DW'($signed(t_in[i]));
      n_d[i]    = DW'($signed(e_in[i])) - DW'($signed(t_in[i]));
    end
    rsum_d = CW'(mover_radius_i) + CW'(target_radius_i);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g0_q   <= g0_d;
      o_q    <= o_d;
      n_q    <= n_d;
      rsum_q <= rsum_d;
    end
  end

  // Stage 1: squares and dot product terms
  geom_t                g1_q;
  logic signed [PW-1:0] msq_q [3];
  logic signed [PW-1:0] osq_q [3];
  logic signed [PW-1:0] nsq1_q [3];
  logic signed [PW-1:0] om_q  [3];
  logic [2*CW-1:0]      r2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      g1_q <= g0_q;
      for (int i = 0; i < 3; i++) begin
        msq_q[i]  <= $signed(g0_q.m[i]) * $signed(g0_q.m[i]);
        osq_q[i]  <= $signed(o_q[i]) * $signed(o_q[i]);
        nsq1_q[i] <= $signed(n_q[i]) * $signed(n_q[i]);
        om_q[i]   <= $signed(o_q[i]) * $signed(g0_q.m[i]);
      end
      r2_q <= rsum_q * rsum_q;
    end
  end

  // Stage 2: quadratic coefficients and end point value
  geom_t                g2_q;
  logic signed [SW-1:0] a2_q, c2_q, bh2_q, p12_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      g2_q  <= g1_q;
      a2_q  <= SW'(msq_q[0]) + SW'(msq_q[1]) + SW'(msq_q[2]);
      c2_q  <= SW'(osq_q[0]) + SW'(osq_q[1]) + SW'(osq_q[2]) - $signed(SW'(r2_q));
      p12_q <= SW'(nsq1_q[0]) + SW'(nsq1_q[1]) + SW'(nsq1_q[2]) - $signed(SW'(r2_q));
      bh2_q <= SW'(om_q[0]) + SW'(om_q[1]) + SW'(om_q[2]);
    end
  end

  // Stage 3: early outcome flags
  geom_t                g3_q;
  flags_t               fl3_d, fl3_q;
  logic signed [SW-1:0] nb3;
  logic [PW-1:0]        a3_q, c3_q, nb3_q;

  always_comb begin
    nb3        = -bh2_q;
    fl3_d.ovl  = c2_q[SW-1] || (c2_q == '0);
    fl3_d.tiny = a2_q[PW-1:0] <= MIN_MOVE_SQ;
    fl3_d.away = !bh2_q[SW-1];
    fl3_d.vb   = a2_q <= nb3;
    fl3_d.p1le = p12_q[SW-1] || (p12_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g3_q  <= g2_q;
      fl3_q <= fl3_d;
      a3_q  <= a2_q[PW-1:0];
      c3_q  <= c2_q[PW-1:0];
      nb3_q <= nb3[PW-1:0];
    end
  end

  // Stage 4: partial products of nb*nb and a*c
  geom_t         g4_q;
  flags_t        fl4_q;
  logic [PW-1:0] a4_q, c4_q, nb4_q;
  logic [PW-1:0] nn_hh_q, nn_hl_q, nn_ll_q;
  logic [PW-1:0] ac_hh_q, ac_hl_q, ac_lh_q, ac_ll_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      g4_q    <= g3_q;
      fl4_q   <= fl3_q;
      a4_q    <= a3_q;
      c4_q    <= c3_q;
      nb4_q   <= nb3_q;
      nn_hh_q <= PW'(nb3_q[PW-1:DW]) * PW'(nb3_q[PW-1:DW]);
      nn_hl_q <= PW'(nb3_q[PW-1:DW]) * PW'(nb3_q[DW-1:0]);
      nn_ll_q <= PW'(nb3_q[DW-1:0]) * PW'(nb3_q[DW-1:0]);
      ac_hh_q <= PW'(a3_q[PW-1:DW]) * PW'(c3_q[PW-1:DW]);
      ac_hl_q <= PW'(a3_q[PW-1:DW]) * PW'(c3_q[DW-1:0]);
      ac_lh_q <= PW'(a3_q[DW-1:0]) * PW'(c3_q[PW-1:DW]);
      ac_ll_q <= PW'(a3_q[DW-1:0]) * PW'(c3_q[DW-1:0]);
    end
  end

  // Stage 5: assemble nb squared and a times c
  geom_t         g5_q;
  flags_t        fl5_q;
  logic [PW-1:0] a5_q, c5_q, nb5_q;
  logic [NW-1:0] nsq5_q, ac5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      g5_q   <= g4_q;
      fl5_q  <= fl4_q;
      a5_q   <= a4_q;
      c5_q   <= c4_q;
      nb5_q  <= nb4_q;
      nsq5_q <= (NW'(nn_hh_q) << PW) + (NW'(nn_hl_q) << (DW + 1)) + NW'(nn_ll_q);
      ac5_q  <= (NW'(ac_hh_q) << PW) + ((NW'(ac_hl_q) + NW'(ac_lh_q)) << DW)
              + NW'(ac_ll_q);
    end
  end

  // Stage 6: hit decision and search start values
  srch_t sr_q [QW+1];
  srch_t sr_d [QW];
  srch_t s6_d;

  always_comb begin
    s6_d.g   = g5_q;
    s6_d.q   = '0;
    s6_d.f   = $signed(FW'(c5_q) << (2 * TIME_BITS));
    s6_d.h   = -$signed(HW'(nb5_q) << (TIME_BITS + 1));
    s6_d.a   = a5_q;
    s6_d.ovl = fl5_q.ovl;
    s6_d.hit = !fl5_q.ovl && !fl5_q.tiny && !fl5_q.away
            && (fl5_q.vb ? fl5_q.p1le : (nsq5_q >= ac5_q));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_q[0] <= s6_d;
    end
  end

  // Time search: one bit per stage, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_srch
    localparam int unsigned B = QW - 1 - k;
    logic signed [HW-1:0] hc;
    logic signed [FW-1:0] fc;
    logic                 ok;

    always_comb begin
      hc = sr_q[k].h + $signed(HW'(sr_q[k].a) << (B + 1));
      fc = sr_q[k].f + (FW'(sr_q[k].h) <<< B) + $signed(FW'(sr_q[k].a) << (2 * B));
      ok = !sr_q[k].q[QW-1] && (hc[HW-1] || (hc == '0)) && !fc[FW-1];
      sr_d[k] = sr_q[k];
      if (ok) begin
        sr_d[k].q = sr_q[k].q | (QW'(1) << B);
        sr_d[k].f = fc;
        sr_d[k].h = hc;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_q[k+1] <= sr_d[k];
      end
    end
  end

  // Position offset products
  logic [2:0][CW-1:0]   s7_q;
  logic [QW-1:0]        q7_q;
  logic                 hit7_q, ovl7_q;
  logic signed [MW-1:0] pr7_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_q   <= sr_q[QW].g.s;
      q7_q   <= sr_q[QW].q;
      hit7_q <= sr_q[QW].hit;
      ovl7_q <= sr_q[QW].ovl;
      for (int i = 0; i < 3; i++) begin
        pr7_q[i] <= $signed(sr_q[QW].g.m[i]) * $signed({1'b0, sr_q[QW].q});
      end
    end
  end

  // Output register: select overlap, hit or no hit result
  logic               hit_q;
  logic [QW-1:0]      time_q;
  logic [2:0][CW-1:0] pos_d, pos_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ovl7_q) begin
        pos_d[i] = s7_q[i];
      end else if (hit7_q) begin
        pos_d[i] = s7_q[i] + pr7_q[i][TIME_BITS +: CW];
      end else begin
        pos_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= ovl7_q || hit7_q;
      time_q <= (!ovl7_q && hit7_q) ? q7_q : '0;
      pos_q  <= pos_d;
    end
  end

  assign hit_o      = hit_q;
  assign hit_time_o = time_q;
  assign hit_x_o    = pos_q[0];
  assign hit_y_o    = pos_q[1];
  assign hit_z_o    = pos_q[2];

endmodule

/* rtl/ssi_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_props
// Port level checks of the swept sphere test, bound to the top level.
// ----------------------------------------------------------------------------
module ssi_props
  import ssi_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               hit_o,
  input logic [16:0]        hit_time_o,
  input logic signed [31:0] hit_x_o,
  input logic signed [31:0] hit_y_o,
  input logic signed [31:0] hit_z_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(hit_time_o) && $stable(hit_x_o))
    else $error("stalled result changed");

  // Stall the input only behind a stalled result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back pressure");

  // A miss carries zero fields
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> hit_time_o == '0 && hit_x_o == '0
                              && hit_y_o == '0 && hit_z_o == '0)
    else $error("miss with nonzero fields");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hit_time_o <= TIME_ONE)
    else $error("contact time above one");

endmodule

bind swept_sphere_intersection ssi_props u_ssi_props (.*);

/* tb/sv/ssi_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_checker
// Watches both channels of the swept sphere block, works out the contact
// result of every query taken in and compares it with each result given out.
// ----------------------------------------------------------------------------
module ssi_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic signed [31:0]  start_x_i,
  input  logic signed [31:0]  start_y_i,
  input  logic signed [31:0]  start_z_i,
  input  logic signed [31:0]  end_x_i,
  input  logic signed [31:0]  end_y_i,
  input  logic signed [31:0]  end_z_i,
  input  logic [30:0]         mover_radius_i,
  input  logic signed [31:0]  target_x_i,
  input  logic signed [31:0]  target_y_i,
  input  logic signed [31:0]  target_z_i,
  input  logic [30:0]         target_radius_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic                hit_i,
  input  logic [16:0]         hit_time_i,
  input  logic signed [31:0]  hit_x_i,
  input  logic signed [31:0]  hit_y_i,
  input  logic signed [31:0]  hit_z_i,
  output int                  err_cnt_o,
  output int                  pending_o,
  output int                  result_cnt_o,
  output int                  hit_cnt_o,
  output int                  swept_hit_cnt_o
);

  typedef logic signed [191:0] big_t;

  localparam longint TIME_ONE_L = 65536;
  localparam longint MOVE_FLOOR = 42;  // 1e-8 at scale 2^32, floored

  typedef struct packed {
    logic               hit;
    logic [16:0]        t;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } contact_t;

  contact_t contact_q[$];

  // Exact contact solution of one sweep query
  function automatic contact_t solve_contact(
    input logic signed [31:0] s[3], input logic signed [31:0] e[3],
    input logic signed [31:0] tg[3], input logic [30:0] mr, input logic [30:0] tr);
    contact_t r;
    longint mv[3], off[3], fin[3];
    longint rsum, pos;
    big_t a, bh, c, p1, nb, lhs, rhs, v, bq;
    logic [16:0] q, cand;
    logic hit;
    r = '0;
    rsum = longint'(mr) + longint'(tr);
    a = '0; bh = '0;
    c = -(big_t'(rsum) * big_t'(rsum));
    p1 = c;
    for (int i = 0; i < 3; i++) begin
      mv[i] = longint'(e[i]) - longint'(s[i]);
      off[i] = longint'(s[i]) - longint'(tg[i]);
      fin[i] = longint'(e[i]) - longint'(tg[i]);
      a += big_t'(mv[i]) * big_t'(mv[i]);
      c += big_t'(off[i]) * big_t'(off[i]);
      p1 += big_t'(fin[i]) * big_t'(fin[i]);
      bh += big_t'(off[i]) * big_t'(mv[i]);
    end
    // overlap at the start: hit at time zero
    if (c <= 0) begin
      r.hit = 1'b1;
      r.x = s[0]; r.y = s[1]; r.z = s[2];
      return r;
    end
    if (a <= big_t'(MOVE_FLOOR) || bh >= 0) return r;
    nb = -bh;
    if (a <= nb) hit = (p1 <= 0);
    else hit = (nb * nb >= a * c);
    if (!hit) return r;
    // floor the smaller root to Q1.16, one bit at a time
    q = '0;
    for (int b = 16; b >= 0; b--) begin
      cand = q | (17'd1 << b);
      if (cand <= 17'd65536) begin
        bq = big_t'(longint'(cand));
        lhs = a * bq;
        rhs = nb * big_t'(TIME_ONE_L);
        v = a * bq * bq - nb * big_t'(2 * TIME_ONE_L) * bq + (c <<< 32);
        if (lhs <= rhs && v >= 0) q = cand;
      end
    end
    r.hit = 1'b1;
    r.t = q;
    pos = longint'(s[0]) + ((mv[0] * longint'(q)) >>> 16); r.x = pos[31:0];
    pos = longint'(s[1]) + ((mv[1] * longint'(q)) >>> 16); r.y = pos[31:0];
    pos = longint'(s[2]) + ((mv[2] * longint'(q)) >>> 16); r.z = pos[31:0];
    return r;
  endfunction

  assign pending_o = contact_q.size();

  // Predict on each input transfer, compare on each output transfer
  always @(posedge clk_i or negedge rst_ni) begin
    contact_t exp_c, got_c;
    logic signed [31:0] s[3], e[3], tg[3];
    if (!rst_ni) begin
      err_cnt_o <= 0;
      result_cnt_o <= 0;
      hit_cnt_o <= 0;
      swept_hit_cnt_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        s = '{start_x_i, start_y_i, start_z_i};
        e = '{end_x_i, end_y_i, end_z_i};
        tg = '{target_x_i, target_y_i, target_z_i};
        contact_q.push_back(solve_contact(s, e, tg, mover_radius_i, target_radius_i));
      end
      if (out_valid_i && !out_stall_i) begin
        got_c = '{hit_i, hit_time_i, hit_x_i, hit_y_i, hit_z_i};
        result_cnt_o <= result_cnt_o + 1;
        if (contact_q.size() == 0) begin
          if (err_cnt_o < 10) $display("ERROR: result with no query pending: %p", got_c);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          exp_c = contact_q.pop_front();
          if (exp_c.hit) hit_cnt_o <= hit_cnt_o + 1;
          if (exp_c.hit && exp_c.t != 0) swept_hit_cnt_o <= swept_hit_cnt_o + 1;
          if (got_c != exp_c) begin
            if (err_cnt_o < 10)
              $display("ERROR: result %0d expected hit=%0d t=%0d x=%0d y=%0d z=%0d, got hit=%0d t=%0d x=%0d y=%0d z=%0d",
                       result_cnt_o, exp_c.hit, exp_c.t, exp_c.x, exp_c.y, exp_c.z,
                       got_c.hit, got_c.t, got_c.x, got_c.y, got_c.z);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Swept sphere contact test bench: directed sweeps, then random queries mostly aimed
// along the sweep, with bursty input and patterned output stalls.
// ----------------------------------------------------------------------------
module tb;
  import ssi_pkg::*;

  localparam int ONE = 65536;
  localparam int NUM_RANDOM = 1600;
  localparam int IDLE_LIMIT = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] start_x_i = '0, start_y_i = '0, start_z_i = '0;
  logic signed [31:0] end_x_i = '0, end_y_i = '0, end_z_i = '0;
  logic [30:0] mover_radius_i = '0, target_radius_i = '0;
  logic signed [31:0] target_x_i = '0, target_y_i = '0, target_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o;
  logic [16:0] hit_time_o;
  logic signed [31:0] hit_x_o, hit_y_o, hit_z_o;

  int err_cnt, pending, result_cnt, hit_cnt, swept_hit_cnt;
  int idle_cycles;
  int burst_left;

  always #5 clk_i = ~clk_i;

  swept_sphere_intersection i_dut (.*);

  ssi_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .start_x_i, .start_y_i, .start_z_i, .end_x_i, .end_y_i, .end_z_i,
    .mover_radius_i, .target_x_i, .target_y_i, .target_z_i, .target_radius_i,
    .out_valid_i(out_valid_o), .out_stall_i, .hit_i(hit_o), .hit_time_i(hit_time_o),
    .hit_x_i(hit_x_o), .hit_y_i(hit_y_o), .hit_z_i(hit_z_o),
    .err_cnt_o(err_cnt), .pending_o(pending), .result_cnt_o(result_cnt),
    .hit_cnt_o(hit_cnt), .swept_hit_cnt_o(swept_hit_cnt)
  );

  // Output stall pattern: switch between free, light, heavy and blocked modes
  always @(posedge clk_i) begin
    int mode, mode_left;
    if (mode_left <= 0) begin
      mode = $urandom_range(0, 3);
      mode_left = $urandom_range(10, 200);
    end
    mode_left--;
    case (mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ($urandom_range(0, 15) < 14);
    endcase
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles", IDLE_LIMIT);
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive one query and hold it until the transfer
  task automatic send_query(input int sx, sy, sz, ex, ey, ez, mr, tx, ty, tz, tr);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    start_x_i <= sx; start_y_i <= sy; start_z_i <= sz;
    end_x_i <= ex; end_y_i <= ey; end_z_i <= ez;
    mover_radius_i <= mr[30:0];
    target_x_i <= tx; target_y_i <= ty; target_z_i <= tz;
    target_radius_i <= tr[30:0];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic int rand_span(input int mag);
    return int'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  // One random query; most are aimed so that the target lies near the path
  task automatic send_random();
    int kind, mag, u, s[3], e[3], tg[3], mr, tr;
    kind = $urandom_range(0, 9);
    mag = 1 << $urandom_range(4, 28);
    for (int i = 0; i < 3; i++) begin
      s[i] = rand_span(mag);
      e[i] = s[i] + rand_span(mag);
    end
    mr = $urandom_range(0, mag / 2);
    tr = $urandom_range(0, mag / 2);
    u = $urandom_range(0, ONE);
    for (int i = 0; i < 3; i++)
      tg[i] = s[i] + int'((longint'(e[i] - s[i]) * u) >>> 16) + rand_span(mag / 4);
    if (kind <= 1) begin
      // raw noise over the full field ranges
      for (int i = 0; i < 3; i++) begin
        s[i] = $urandom; e[i] = $urandom; tg[i] = $urandom;
      end
      mr = $urandom; tr = $urandom;
      if (kind == 1) begin
        mr = mr >> $urandom_range(0, 30);
        tr = tr >> $urandom_range(0, 30);
      end
    end else if (kind == 8) begin
      // barely moving
      for (int i = 0; i < 3; i++) e[i] = s[i] + int'($urandom_range(0, 8)) - 4;
    end else if (kind == 9) begin
      // thin spheres, often pointing away
      mr = $urandom_range(0, 64);
      tr = $urandom_range(0, 64);
    end
    send_query(s[0], s[1], s[2], e[0], e[1], e[2], mr, tg[0], tg[1], tg[2], tr);
  endtask

  initial begin
    int imax, imin;
    imax = 32'h7fffffff;
    imin = 32'h80000000;
    burst_left = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sweeps
    send_query(0, 0, 0, 10*ONE, 0, 0, ONE, 0, 0, 0, ONE);          // overlap at start
    send_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);                   // touching, zero radii
    send_query(0, 0, 0, 0, 0, 0, ONE, 9*ONE, 0, 0, ONE);           // no movement
    send_query(0, 0, 0, 6, 0, 0, ONE, 2*ONE+3, 0, 0, ONE);         // movement under floor
    send_query(0, 0, 0, 7, 0, 0, ONE, 2*ONE+3, 0, 0, ONE);         // movement just above
    send_query(0, 0, 0, -10*ONE, 0, 0, ONE, 5*ONE, 0, 0, ONE);     // moving away
    send_query(0, 0, 0, 10*ONE, 0, 0, ONE, 5*ONE, 0, 0, ONE);      // head on, mid sweep
    send_query(0, 0, 0, 4*ONE, 0, 0, ONE, 5*ONE, 0, 0, ONE);       // vertex beyond end, hit
    send_query(0, 0, 0, 2*ONE, 0, 0, ONE, 5*ONE, 0, 0, ONE);       // vertex beyond end, miss
    send_query(0, 0, 0, 3*ONE, 0, 0, ONE, 5*ONE, 0, 0, ONE);       // contact at the very end
    send_query(0, 0, 0, 10*ONE, 0, 0, ONE, 5*ONE, 2*ONE, 0, ONE);  // grazing contact
    send_query(0, 0, 0, 10*ONE, 0, 0, ONE, 5*ONE, 3*ONE, 0, ONE);  // negative discriminant
    send_query(10*ONE, 10*ONE, 10*ONE, -10*ONE, -10*ONE, -10*ONE, ONE, 0, 0, 0, ONE);
    send_query(-7*ONE, 3*ONE, -2*ONE, 8*ONE, -ONE, 5*ONE, 3, 2*ONE, 0, 0, ONE/2);
    send_query(imax, imax, imax, imax, imax, imax, imax, imax, imax, imax, imax);
    send_query(imin, imin, imin, imax, imax, imax, 0, 0, 0, 0, 0);
    send_query(imax, imax, imax, imin, imin, imin, 0, 0, 0, 0, 1);
    send_query(imin, imin, imin, imax, imax, imax, imax, imin, imin, imin, imax);
    send_query(imin, 0, imax, imax, 0, imin, 0, imin, imax, 0, 0);
    send_query(imax, imax, imax, imin, imin, imin, 0, imax, imax, imax, 0);

    // Random queries, with one full drain in the middle
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 2) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
        burst_left = 0;
      end
      send_random();
    end
    in_valid_i <= 1'b0;

    // Drain, then allow for the pipeline depth
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("tb: %0d queries checked, %0d hits, %0d of them at a time inside the sweep",
             result_cnt, hit_cnt, swept_hit_cnt);
    $display("tb: %0d mismatches", err_cnt);
    if (err_cnt == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
